### hdl/pat_program_table_tracker_assert.svh
// assertion macros shared by the program table tracker modules
`ifndef PAT_PROGRAM_TABLE_TRACKER_ASSERT_SVH
`define PAT_PROGRAM_TABLE_TRACKER_ASSERT_SVH

// same-cycle implication under synchronous reset
`define PAT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pat assertion failed");

// next-cycle implication under synchronous reset
`define PAT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pat assertion failed");

`endif

### hdl/pat_pkg.sv
// shared types and codes of the program table tracker
`timescale 1ns / 1ps
package pat_pkg;

   typedef enum logic [2:0] {
      OP_HEADER = 3'd0,
      OP_ENTRY  = 3'd1,
      OP_SECEND = 3'd2,
      OP_LOOKUP = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef struct packed {
      logic accept;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic has_result;
      logic out_busy;
   } stat_type;

endpackage

### hdl/pat_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pat_ram #(
   parameter int WIDTH = 29,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### hdl/pat_ctl.sv
// controller state machine of the program table tracker
`timescale 1ns / 1ps
`include "pat_program_table_tracker_assert.svh"
module pat_ctl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pat_pkg::stat_type stat,
   output pat_pkg::cmd_type  cmd
);
   import pat_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept && stat.need_scan) state_in = ST_SCAN;
         ST_SCAN:   if (stat.scan_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (!(stat.has_result && stat.out_busy)) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SCAN:   cmd.step = 1'b1;
         ST_DRAIN:  cmd = '0;
         ST_FINISH: cmd.finish = !(stat.has_result && stat.out_busy);
         default:   cmd = '0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PAT_ASSERT_NEXT(a_scan_start, clock, reset, accept && stat.need_scan, state_ff == ST_SCAN)
   `PAT_ASSERT_NEXT(a_drain_follows, clock, reset,
                    state_ff == ST_SCAN && stat.scan_last, state_ff == ST_DRAIN)
endmodule

### hdl/pat_dp.sv
// datapath of the program table tracker: table, flags, scan and result register
`timescale 1ns / 1ps
`include "pat_program_table_tracker_assert.svh"
module pat_dp #(
   parameter int MAX_PROGRAMS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_table_id,
   input  logic [4:0]        req_section_version,
   input  logic              req_current_next,
   input  logic [15:0]       req_program_number,
   input  logic [15:0]       req_pid_word,
   input  pat_pkg::cmd_type  cmd,
   output pat_pkg::stat_type stat,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic              rsp_kind,
   output logic              rsp_changed,
   output logic [4:0]        rsp_version_out,
   output logic [12:0]       rsp_network_id,
   output logic [5:0]        rsp_program_count,
   output logic              rsp_found,
   output logic [12:0]       rsp_pid_out,
   output logic [4:0]        rsp_rank,
   output logic              rsp_overflow
);
   import pat_pkg::*;

   localparam int IDX_W = MAX_PROGRAMS > 1 ? $clog2(MAX_PROGRAMS) : 1;
   localparam int CNT_W = $clog2(MAX_PROGRAMS + 1);

   op_type                  op_ff;
   logic [15:0]             key_ff;
   logic [12:0]             pid_ff;
   logic [IDX_W-1:0]        scan_ff;
   logic [IDX_W-1:0]        idx_d_ff;
   logic                    pend_ff;
   logic [MAX_PROGRAMS-1:0] valid_ff;
   logic [MAX_PROGRAMS-1:0] seen_ff;
   logic [4:0]              ver_ff;
   logic [12:0]             net_ff;
   logic                    chg_ff;
   logic                    ign_ff;
   logic                    ovf_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    hit_ff;
   logic [IDX_W-1:0]        hit_idx_ff;
   logic [12:0]             hit_pid_ff;
   logic                    free_ff;
   logic [IDX_W-1:0]        free_idx_ff;
   logic [CNT_W-1:0]        below_ff;
   logic                    rsp_valid_ff;

   logic [28:0]             rd_data;
   logic [15:0]             rd_num;
   logic [12:0]             rd_pid;
   logic                    ram_we;
   op_type                  req_code;
   logic [CNT_W+5:0]        cnt_ext;
   logic [CNT_W+4:0]        below_ext;

   assign req_code = op_type'(req_op);
   assign rd_num   = rd_data[28:13];
   assign rd_pid   = rd_data[12:0];
   assign cnt_ext   = {6'd0, cnt_ff};
   assign below_ext = {5'd0, below_ff};

   // status toward the controller
   always_comb begin
      stat.need_scan  = (req_code == OP_LOOKUP)
                     || (req_code == OP_ENTRY && !ign_ff && req_program_number != 16'd0)
                     || (req_code == OP_SECEND && !ign_ff);
      stat.scan_last  = (scan_ff == IDX_W'(MAX_PROGRAMS - 1));
      stat.has_result = (op_ff == OP_LOOKUP) || (op_ff == OP_SECEND);
      stat.out_busy   = rsp_valid_ff && rsp_stall;
   end

   // new program goes in at the end of an entry scan
   assign ram_we = cmd.finish && op_ff == OP_ENTRY && !hit_ff && free_ff;

   pat_ram #(.WIDTH(29), .DEPTH(MAX_PROGRAMS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_idx_ff),
      .wr_data ({key_ff, pid_ff}),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   // latched item fields and scan bookkeeping
   always_ff @(posedge clock) begin
      idx_d_ff <= scan_ff;
      if (cmd.accept) begin
         op_ff  <= req_code;
         key_ff <= req_program_number;
         pid_ff <= req_pid_word[12:0];
      end
      if (pend_ff && valid_ff[idx_d_ff] && rd_num == key_ff && !hit_ff) begin
         hit_idx_ff <= idx_d_ff;
         hit_pid_ff <= rd_pid;
      end
      if (pend_ff && !valid_ff[idx_d_ff] && !free_ff) begin
         free_idx_ff <= idx_d_ff;
      end
   end

   // control state: table flags, section flags, counters and result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         seen_ff      <= '0;
         ver_ff       <= '0;
         net_ff       <= '0;
         chg_ff       <= 1'b0;
         ign_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         scan_ff      <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         below_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !(cmd.finish && stat.has_result))
            rsp_valid_ff <= 1'b0;
         pend_ff <= cmd.step;
         if (cmd.step) scan_ff <= scan_ff + IDX_W'(1);

         // item acceptance: start a scan or apply an op that needs no scan
         if (cmd.accept) begin
            scan_ff  <= '0;
            hit_ff   <= 1'b0;
            free_ff  <= 1'b0;
            below_ff <= '0;
            if (!stat.need_scan) begin
               case (req_code)
                  OP_HEADER: begin
                     seen_ff <= '0;
                     ovf_ff  <= 1'b0;
                     if (req_table_id != 8'd0) begin
                        ign_ff <= 1'b1;
                        chg_ff <= 1'b0;
                     end else begin
                        ign_ff <= 1'b0;
                        chg_ff <= !req_current_next || (req_section_version != ver_ff);
                        ver_ff <= req_section_version;
                     end
                  end
                  OP_ENTRY: begin
                     if (!ign_ff) net_ff <= req_pid_word[12:0];
                  end
                  OP_SECEND: begin
                     seen_ff <= '0;
                     chg_ff  <= 1'b0;
                     ign_ff  <= 1'b0;
                     ovf_ff  <= 1'b0;
                  end
                  OP_CLEAR: begin
                     valid_ff <= '0;
                     seen_ff  <= '0;
                     ver_ff   <= '0;
                     net_ff   <= '0;
                     chg_ff   <= 1'b0;
                     ign_ff   <= 1'b0;
                     ovf_ff   <= 1'b0;
                     cnt_ff   <= '0;
                  end
                  default: ;
               endcase
            end
         end

         // one table entry per cycle
         if (pend_ff) begin
            case (op_ff)
               OP_ENTRY: begin
                  if (valid_ff[idx_d_ff] && rd_num == key_ff) hit_ff <= 1'b1;
                  if (!valid_ff[idx_d_ff]) free_ff <= 1'b1;
               end
               OP_LOOKUP: begin
                  if (valid_ff[idx_d_ff] && rd_num == key_ff) hit_ff <= 1'b1;
                  else if (valid_ff[idx_d_ff] && rd_num < key_ff)
                     below_ff <= below_ff + CNT_W'(1);
               end
               OP_SECEND: begin
                  if (valid_ff[idx_d_ff] && !seen_ff[idx_d_ff]) begin
                     valid_ff[idx_d_ff] <= 1'b0;
                     cnt_ff             <= cnt_ff - CNT_W'(1);
                     chg_ff             <= 1'b1;
                  end
               end
               default: ;
            endcase
         end

         // end of scan: table update and result
         if (cmd.finish) begin
            case (op_ff)
               OP_ENTRY: begin
                  if (hit_ff) begin
                     seen_ff[hit_idx_ff] <= 1'b1;
                  end else if (free_ff) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                     seen_ff[free_idx_ff]  <= 1'b1;
                     cnt_ff                <= cnt_ff + CNT_W'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
               end
               OP_SECEND: begin
                  rsp_valid_ff <= 1'b1;
                  seen_ff      <= '0;
                  chg_ff       <= 1'b0;
                  ign_ff       <= 1'b0;
                  ovf_ff       <= 1'b0;
               end
               OP_LOOKUP: rsp_valid_ff <= 1'b1;
               default: ;
            endcase
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.finish && stat.has_result) begin
         rsp_version_out   <= ver_ff;
         rsp_network_id    <= net_ff;
         rsp_program_count <= cnt_ext[5:0];
         if (op_ff == OP_LOOKUP) begin
            rsp_kind     <= KIND_LOOKUP;
            rsp_changed  <= 1'b0;
            rsp_overflow <= 1'b0;
            rsp_found    <= hit_ff;
            rsp_pid_out  <= hit_ff ? hit_pid_ff : 13'd0;
            rsp_rank     <= hit_ff ? below_ext[4:0] : 5'd0;
         end else begin
            rsp_kind     <= KIND_REPORT;
            rsp_changed  <= chg_ff;
            rsp_overflow <= ovf_ff;
            rsp_found    <= 1'b0;
            rsp_pid_out  <= 13'd0;
            rsp_rank     <= 5'd0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PAT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_PROGRAMS))
   `PAT_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.finish && stat.has_result,
                   !stat.out_busy)
endmodule

### hdl/pat_program_table_tracker.sv
// top level of the program association table tracker
`timescale 1ns / 1ps
// Program association table tracker. Items arrive on the req_ channel and results
// leave on the rsp_ channel through an output register. Header, clear, section end
// of an ignored section, network entries, entries of an ignored section and unused
// op codes are applied when accepted, with no scan. A program entry, a lookup and a
// section end each walk the whole table through the single read port of the entry
// memory, one entry a cycle; req_stall holds off the next item until the item is
// done. A result may wait in the output register while the next item is taken;
// a second result then waits for the first to be transferred.
module pat_program_table_tracker #(
   parameter int MAX_PROGRAMS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_table_id,
   input  logic [4:0]  req_section_version,
   input  logic        req_current_next,
   input  logic [15:0] req_program_number,
   input  logic [15:0] req_pid_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic        rsp_changed,
   output logic [4:0]  rsp_version_out,
   output logic [12:0] rsp_network_id,
   output logic [5:0]  rsp_program_count,
   output logic        rsp_found,
   output logic [12:0] rsp_pid_out,
   output logic [4:0]  rsp_rank,
   output logic        rsp_overflow
);
   import pat_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller
   pat_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   pat_dp #(.MAX_PROGRAMS(MAX_PROGRAMS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_op              (req_op),
      .req_table_id        (req_table_id),
      .req_section_version (req_section_version),
      .req_current_next    (req_current_next),
      .req_program_number  (req_program_number),
      .req_pid_word        (req_pid_word),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_changed         (rsp_changed),
      .rsp_version_out     (rsp_version_out),
      .rsp_network_id      (rsp_network_id),
      .rsp_program_count   (rsp_program_count),
      .rsp_found           (rsp_found),
      .rsp_pid_out         (rsp_pid_out),
      .rsp_rank            (rsp_rank),
      .rsp_overflow        (rsp_overflow)
   );
endmodule
